/* sv/triangular_matrix_unpack_addresses_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the triangular matrix unpack block
// Clocked assertion helpers; defining ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef TRIANGULAR_MATRIX_UNPACK_ADDRESSES_CORE_DEFINES_SVH
`define TRIANGULAR_MATRIX_UNPACK_ADDRESSES_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked at every rising edge of clk outside reset.
`define TMU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define TMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMU_ASSERT(lbl, prop, msg)
`define TMU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/tmu_pkg.sv */
// ----------------------------------------------------------------------------
// tmu_pkg
// Layout and shape codes, register indexes and layout decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tmu_pkg;

    localparam int MAX_N_DEFAULT = 1024;
    localparam int WEIGHT_W      = 32;
    localparam int LAYOUT_W      = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int SHAPE_W       = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;

    // Packed layouts.
    localparam logic [LAYOUT_W-1:0] LAY_FULL            = 4'd0;
    localparam logic [LAYOUT_W-1:0] LAY_UPPER_ROW       = 4'd1;
    localparam logic [LAYOUT_W-1:0] LAY_LOWER_ROW       = 4'd2;
    localparam logic [LAYOUT_W-1:0] LAY_UPPER_DIAG_ROW  = 4'd3;
    localparam logic [LAYOUT_W-1:0] LAY_LOWER_DIAG_ROW  = 4'd4;
    localparam logic [LAYOUT_W-1:0] LAY_UPPER_COL       = 4'd5;
    localparam logic [LAYOUT_W-1:0] LAY_LOWER_COL       = 4'd6;
    localparam logic [LAYOUT_W-1:0] LAY_UPPER_DIAG_COL  = 4'd7;
    localparam logic [LAYOUT_W-1:0] LAY_LOWER_DIAG_COL  = 4'd8;

    // Traversal shapes in terms of the outer and inner loop counters.
    localparam logic [SHAPE_W-1:0] SH_FULL       = 3'd0;
    localparam logic [SHAPE_W-1:0] SH_UPPER      = 3'd1;
    localparam logic [SHAPE_W-1:0] SH_LOWER      = 3'd2;
    localparam logic [SHAPE_W-1:0] SH_UPPER_DIAG = 3'd3;
    localparam logic [SHAPE_W-1:0] SH_LOWER_DIAG = 3'd4;

    // A column-wise upper layout walks the same cells as a row-wise lower one
    // with the loop roles swapped, so it maps to the opposite shape.
    function automatic logic [SHAPE_W-1:0] shape_of(input logic [LAYOUT_W-1:0] lay);
        logic [SHAPE_W-1:0] sh;
        unique case (lay) inside
            LAY_UPPER_ROW, LAY_LOWER_COL:           sh = SH_UPPER;
            LAY_LOWER_ROW, LAY_UPPER_COL:           sh = SH_LOWER;
            LAY_UPPER_DIAG_ROW, LAY_LOWER_DIAG_COL: sh = SH_UPPER_DIAG;
            LAY_LOWER_DIAG_ROW, LAY_UPPER_DIAG_COL: sh = SH_LOWER_DIAG;
            default:                                sh = SH_FULL;
        endcase
        return sh;
    endfunction

    function automatic logic col_wise(input logic [LAYOUT_W-1:0] lay);
        return (lay >= LAY_UPPER_COL) && (lay <= LAY_LOWER_DIAG_COL);
    endfunction

endpackage

`default_nettype wire

/* sv/triangular_matrix_unpack_addresses_core.sv */
// ----------------------------------------------------------------------------
// triangular_matrix_unpack_addresses_core: packed weights to matrix writes
// A request passes through the request stage and then the output register; a
// diagonal or full value gives one write and a mirrored value two, one at a time.
// Reset restores the full layout with N = 2 and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangular_matrix_unpack_addresses_core_defines.svh"

module triangular_matrix_unpack_addresses_core
    import tmu_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT,
    localparam int IDX_W  = $clog2(MAX_N),
    localparam int ADDR_W = 2 * IDX_W,
    localparam int NC_W   = ($clog2(MAX_N + 1) > 11) ? $clog2(MAX_N + 1) : 11
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [NC_W-1:0]            cfg_data,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [WEIGHT_W-1:0] weight,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [IDX_W-1:0]                row,
    output logic [IDX_W-1:0]                col,
    output logic [ADDR_W-1:0]               cell_address,
    output logic signed [WEIGHT_W-1:0]      cell_value,
    output logic                            last_of_run,
    output logic                            section_done
);

    typedef struct packed {
        logic [IDX_W-1:0]  outer;
        logic [IDX_W-1:0]  inner;
        logic [ADDR_W-1:0] obase;
        logic [ADDR_W-1:0] ibase;
    } trav_t;

    typedef struct packed {
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  c;
        logic [ADDR_W-1:0] addr;
    } wr_t;

    localparam logic [NC_W-1:0] N_MIN = NC_W'(2);
    localparam logic [NC_W-1:0] N_MAX = NC_W'(MAX_N);

    // Start of traversal: only the strict shapes begin off the origin.
    function automatic trav_t start_of(input logic [SHAPE_W-1:0] sh,
                                       input logic [NC_W-1:0] n);
        trav_t t;
        t.outer = (sh == SH_LOWER) ? IDX_W'(1) : '0;
        t.obase = (sh == SH_LOWER) ? ADDR_W'(n) : '0;
        t.inner = (sh == SH_UPPER) ? IDX_W'(1) : '0;
        t.ibase = (sh == SH_UPPER) ? ADDR_W'(n) : '0;
        return t;
    endfunction

    function automatic logic [NC_W-1:0] clamp_n(input logic [NC_W-1:0] v);
        logic [NC_W-1:0] r;
        if (v < N_MIN)
            r = N_MIN;
        else if (v > N_MAX)
            r = N_MAX;
        else
            r = v;
        return r;
    endfunction

    logic [SHAPE_W-1:0]         shape_reg, shape_next;
    logic                       cw_reg, cw_next;
    logic [NC_W-1:0]            n_reg, n_next;
    trav_t                      trav_reg, trav_next;

    logic                       job_valid_reg, job_valid_next;
    logic                       job_two_reg, job_two_next;
    logic                       job_phase_reg, job_phase_next;
    logic                       job_done_reg, job_done_next;
    logic signed [WEIGHT_W-1:0] job_value_reg, job_value_next;
    wr_t                        job_first_reg, job_first_next;
    wr_t                        job_second_reg, job_second_next;

    logic                       out_valid_reg, out_valid_next;
    wr_t                        out_wr_reg, out_wr_next;
    logic signed [WEIGHT_W-1:0] out_value_reg, out_value_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_done_reg, out_done_next;

    logic [NC_W-1:0]            inner_hi;
    logic [NC_W-1:0]            outer_last;
    logic                       more_inner;
    logic                       last_outer;
    logic                       done;
    logic                       single;
    wr_t                        wr_a, wr_b;
    logic [ADDR_W-1:0]          obase_step;
    logic [ADDR_W-1:0]          n_addr;
    logic                       cfg_hit;
    logic [SHAPE_W-1:0]         cfg_shape;
    logic [NC_W-1:0]            cfg_n;
    logic                       in_accept;
    logic                       out_load;
    logic                       job_final;
    logic                       job_free;

    // Current position and the two candidate writes.
    always_comb
    begin
        n_addr = ADDR_W'(n_reg);
        case (shape_reg)
            SH_LOWER:      inner_hi = NC_W'(trav_reg.outer) - NC_W'(1);
            SH_LOWER_DIAG: inner_hi = NC_W'(trav_reg.outer);
            default:       inner_hi = n_reg - NC_W'(1);
        endcase
        outer_last = (shape_reg == SH_UPPER) ? (n_reg - NC_W'(2)) : (n_reg - NC_W'(1));
        more_inner = NC_W'(trav_reg.inner) < inner_hi;
        last_outer = NC_W'(trav_reg.outer) >= outer_last;
        done       = !more_inner && last_outer;
        single     = (shape_reg == SH_FULL) || (trav_reg.outer == trav_reg.inner);

        wr_a.r    = trav_reg.outer;
        wr_a.c    = trav_reg.inner;
        wr_a.addr = trav_reg.obase + ADDR_W'(trav_reg.inner);
        wr_b.r    = trav_reg.inner;
        wr_b.c    = trav_reg.outer;
        wr_b.addr = trav_reg.ibase + ADDR_W'(trav_reg.outer);
        obase_step = trav_reg.obase + n_addr;
    end

    // Handshake control.
    always_comb
    begin
        out_load  = job_valid_reg && (!out_valid_reg || out_ready);
        job_final = !job_two_reg || job_phase_reg;
        job_free  = out_load && job_final;
        in_ready  = !job_valid_reg || job_free;
        in_accept = in_valid && in_ready;
    end

    // Configuration and traversal state.
    always_comb
    begin
        cfg_hit   = cfg_we && ((cfg_index == REG_LAYOUT) || (cfg_index == REG_NODE_COUNT));
        cfg_shape = (cfg_index == REG_LAYOUT) ? shape_of(cfg_data[LAYOUT_W-1:0]) : shape_reg;
        cfg_n     = (cfg_index == REG_NODE_COUNT) ? clamp_n(cfg_data) : n_reg;

        shape_next = shape_reg;
        cw_next    = cw_reg;
        n_next     = n_reg;
        trav_next  = trav_reg;

        if (cfg_hit)
        begin
            shape_next = cfg_shape;
            n_next     = cfg_n;
            if (cfg_index == REG_LAYOUT)
                cw_next = col_wise(cfg_data[LAYOUT_W-1:0]);
            trav_next = start_of(cfg_shape, cfg_n);
        end
        else if (in_accept)
        begin
            if (more_inner)
            begin
                trav_next.inner = trav_reg.inner + IDX_W'(1);
                trav_next.ibase = trav_reg.ibase + n_addr;
            end
            else if (last_outer)
            begin
                trav_next = start_of(shape_reg, n_reg);
            end
            else
            begin
                trav_next.outer = trav_reg.outer + IDX_W'(1);
                trav_next.obase = obase_step;
                case (shape_reg)
                    SH_UPPER:
                    begin
                        trav_next.inner = trav_reg.outer + IDX_W'(2);
                        trav_next.ibase = obase_step + n_addr;
                    end
                    SH_UPPER_DIAG:
                    begin
                        trav_next.inner = trav_reg.outer + IDX_W'(1);
                        trav_next.ibase = obase_step;
                    end
                    default:
                    begin
                        trav_next.inner = '0;
                        trav_next.ibase = '0;
                    end
                endcase
            end
        end
    end

    // Request stage: holds both writes of the accepted value.
    always_comb
    begin
        job_valid_next  = job_valid_reg;
        job_two_next    = job_two_reg;
        job_phase_next  = job_phase_reg;
        job_done_next   = job_done_reg;
        job_value_next  = job_value_reg;
        job_first_next  = job_first_reg;
        job_second_next = job_second_reg;

        if (in_accept)
        begin
            job_valid_next  = 1'b1;
            job_phase_next  = 1'b0;
            job_two_next    = !single;
            job_done_next   = done;
            job_value_next  = weight;
            // Column-wise layouts write the mirrored cell first.
            job_first_next  = (single || !cw_reg) ? wr_a : wr_b;
            job_second_next = cw_reg ? wr_a : wr_b;
        end
        else if (job_free)
        begin
            job_valid_next = 1'b0;
            job_phase_next = 1'b0;
        end
        else if (out_load)
        begin
            job_phase_next = 1'b1;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_wr_next    = out_wr_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_wr_next    = job_phase_reg ? job_second_reg : job_first_reg;
            out_value_next = job_value_reg;
            out_last_next  = job_final;
            out_done_next  = job_done_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg     <= SH_FULL;
            cw_reg        <= 1'b0;
            n_reg         <= N_MIN;
            trav_reg      <= '0;
            job_valid_reg <= 1'b0;
            job_phase_reg <= 1'b0;
            job_two_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shape_reg     <= shape_next;
            cw_reg        <= cw_next;
            n_reg         <= n_next;
            trav_reg      <= trav_next;
            job_valid_reg <= job_valid_next;
            job_phase_reg <= job_phase_next;
            job_two_reg   <= job_two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_done_reg   <= job_done_next;
        job_value_reg  <= job_value_next;
        job_first_reg  <= job_first_next;
        job_second_reg <= job_second_next;
        out_wr_reg     <= out_wr_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    assign out_valid    = out_valid_reg;
    assign row          = out_wr_reg.r;
    assign col          = out_wr_reg.c;
    assign cell_address = out_wr_reg.addr;
    assign cell_value   = out_value_reg;
    assign last_of_run  = out_last_reg;
    assign section_done = out_done_reg;

    // The second write phase only exists for mirrored values.
    `TMU_ASSERT(a_phase_needs_pair, job_phase_reg |-> (job_valid_reg && job_two_reg), "second write phase without a mirrored value")
    // An accepted request always lands in the request stage.
    `TMU_ASSERT_NEXT(a_accept_fills_job, in_valid && in_ready, job_valid_reg, "accepted request was dropped")
    // While the first write of a pair is shown, its partner is still held.
    `TMU_ASSERT(a_pair_pending, (out_valid && !last_of_run) |-> (job_valid_reg && job_phase_reg), "mirrored write lost its partner")
    // The loop counters never leave the matrix.
    `TMU_ASSERT(a_index_in_range, (NC_W'(trav_reg.outer) < n_reg) && (NC_W'(trav_reg.inner) < n_reg), "traversal index beyond node count")

endmodule

`default_nettype wire

/* tb/tmu_cell_write_checker.sv */
// ----------------------------------------------------------------------------
// tmu_cell_write_checker: matrix write predictor and scoreboard
// Follows register writes and accepted weights, works out the matrix cell
// writes each weight must produce, and compares every accepted write with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tmu_cell_write_checker
    import tmu_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT,
    localparam int IDX_W      = $clog2(MAX_N),
    localparam int ADDR_W     = 2 * IDX_W,
    localparam int CFG_DATA_W = ($clog2(MAX_N + 1) > 11) ? $clog2(MAX_N + 1) : 11
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [IDX_W-1:0]           row,
    input  wire logic [IDX_W-1:0]           col,
    input  wire logic [ADDR_W-1:0]          cell_address,
    input  wire logic signed [WEIGHT_W-1:0] cell_value,
    input  wire logic                       last_of_run,
    input  wire logic                       section_done,
    output int                              mismatch_count,
    output int                              pending_writes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic [ADDR_W-1:0]          address;
        logic signed [WEIGHT_W-1:0] value;
        logic                       last_write;
        logic                       section_end;
    } cell_write_t;

    cell_write_t predicted_writes[$];

    logic [LAYOUT_W-1:0]   layout_reg;
    logic [CFG_DATA_W-1:0] node_count_reg;
    logic [IDX_W-1:0]      outer_idx;
    logic [IDX_W-1:0]      inner_idx;
    logic [ADDR_W-1:0]     outer_base;
    logic [ADDR_W-1:0]     inner_base;

    // Out-of-range node counts are clamped to the supported span.
    function automatic logic [CFG_DATA_W-1:0] active_nodes();
        if (node_count_reg < CFG_DATA_W'(2))
            return CFG_DATA_W'(2);
        if (node_count_reg > CFG_DATA_W'(MAX_N))
            return CFG_DATA_W'(MAX_N);
        return node_count_reg;
    endfunction

    // Column-wise layouts walk the mirror image of the row-wise ones, so an
    // upper column layout traverses like a lower row layout.
    function automatic logic [SHAPE_W-1:0] traversal_shape(input logic [LAYOUT_W-1:0] lay);
        case (lay)
            LAY_UPPER_ROW, LAY_LOWER_COL:           return SH_UPPER;
            LAY_LOWER_ROW, LAY_UPPER_COL:           return SH_LOWER;
            LAY_UPPER_DIAG_ROW, LAY_LOWER_DIAG_COL: return SH_UPPER_DIAG;
            LAY_LOWER_DIAG_ROW, LAY_UPPER_DIAG_COL: return SH_LOWER_DIAG;
            default:                                return SH_FULL;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] inner_first(input logic [SHAPE_W-1:0] sh,
                                                     input logic [IDX_W-1:0] o);
        if (sh == SH_UPPER)
            return o + IDX_W'(1);
        if (sh == SH_UPPER_DIAG)
            return o;
        return '0;
    endfunction

    function automatic logic [IDX_W-1:0] inner_last(input logic [SHAPE_W-1:0] sh,
                                                    input logic [IDX_W-1:0] o,
                                                    input logic [CFG_DATA_W-1:0] n);
        if (sh == SH_LOWER)
            return o - IDX_W'(1);
        if (sh == SH_LOWER_DIAG)
            return o;
        return IDX_W'(n - CFG_DATA_W'(1));
    endfunction

    // Appends one predicted write at the tail of the queue.
    function automatic void queue_write(input cell_write_t w);
        predicted_writes = {predicted_writes, w};
    endfunction

    function automatic void restart_traversal();
        logic [CFG_DATA_W-1:0] n;
        logic [SHAPE_W-1:0]    sh;
        n = active_nodes();
        sh = traversal_shape(layout_reg);
        outer_idx = (sh == SH_LOWER) ? IDX_W'(1) : '0;
        outer_base = ADDR_W'(outer_idx) * ADDR_W'(n);
        inner_idx = inner_first(sh, outer_idx);
        inner_base = ADDR_W'(inner_idx) * ADDR_W'(n);
    endfunction

    function automatic void predict_cell_writes(input logic signed [WEIGHT_W-1:0] w);
        logic [CFG_DATA_W-1:0] n;
        logic [SHAPE_W-1:0]    sh;
        logic                  by_column;
        logic [IDX_W-1:0]      o;
        logic [IDX_W-1:0]      i;
        logic [IDX_W-1:0]      i_end;
        logic [IDX_W-1:0]      o_end;
        logic                  wraps;
        cell_write_t           straight;
        cell_write_t           mirrored;
        n = active_nodes();
        sh = traversal_shape(layout_reg);
        by_column = (layout_reg >= LAY_UPPER_COL) && (layout_reg <= LAY_LOWER_DIAG_COL);
        o = outer_idx;
        i = inner_idx;
        i_end = inner_last(sh, o, n);
        o_end = (sh == SH_UPPER) ? IDX_W'(n - CFG_DATA_W'(2)) : IDX_W'(n - CFG_DATA_W'(1));
        wraps = (i >= i_end) && (o >= o_end);

        straight.row = o;
        straight.col = i;
        straight.address = outer_base + ADDR_W'(i);
        straight.value = w;
        straight.last_write = 1'b1;
        straight.section_end = wraps;
        mirrored.row = i;
        mirrored.col = o;
        mirrored.address = inner_base + ADDR_W'(o);
        mirrored.value = w;
        mirrored.last_write = 1'b1;
        mirrored.section_end = wraps;

        if (sh == SH_FULL || o == i)
            queue_write(straight);
        else if (!by_column)
        begin
            straight.last_write = 1'b0;
            queue_write(straight);
            queue_write(mirrored);
        end
        else
        begin
            mirrored.last_write = 1'b0;
            queue_write(mirrored);
            queue_write(straight);
        end

        if (i < i_end)
        begin
            inner_idx = i + IDX_W'(1);
            inner_base = inner_base + ADDR_W'(n);
        end
        else if (o >= o_end)
            restart_traversal();
        else
        begin
            outer_idx = o + IDX_W'(1);
            outer_base = outer_base + ADDR_W'(n);
            inner_idx = inner_first(sh, outer_idx);
            inner_base = ADDR_W'(inner_idx) * ADDR_W'(n);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_write_t got;
        cell_write_t want;
        if (!rst_n)
        begin
            layout_reg = LAY_FULL;
            node_count_reg = CFG_DATA_W'(2);
            restart_traversal();
            predicted_writes.delete();
            mismatch_count <= 0;
            pending_writes <= 0;
        end
        else
        begin
            // Only the two defined registers restart the traversal.
            if (cfg_we)
            begin
                if (cfg_index == REG_LAYOUT)
                begin
                    layout_reg = cfg_data[LAYOUT_W-1:0];
                    restart_traversal();
                end
                else if (cfg_index == REG_NODE_COUNT)
                begin
                    node_count_reg = cfg_data;
                    restart_traversal();
                end
            end

            if (in_valid && in_ready)
                predict_cell_writes(weight);

            if (out_valid && out_ready)
            begin
                got.row = row;
                got.col = col;
                got.address = cell_address;
                got.value = cell_value;
                got.last_write = last_of_run;
                got.section_end = section_done;
                if (predicted_writes.size() == 0)
                begin
                    $display("%0t: unexpected write row %0d col %0d addr %0d value %0d",
                             $time, got.row, got.col, got.address, got.value);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = predicted_writes.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: write mismatch, expected row %0d col %0d addr %0d",
                                 $time, want.row, want.col, want.address,
                                 " value %0d last %0b done %0b",
                                 want.value, want.last_write, want.section_end);
                        $display("%0t:                  actual row %0d col %0d addr %0d",
                                 $time, got.row, got.col, got.address,
                                 " value %0d last %0b done %0b",
                                 got.value, got.last_write, got.section_end);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_writes <= predicted_writes.size();
        end
    end

endmodule

/* tb/triangular_matrix_unpack_addresses_core_test.sv */
// ----------------------------------------------------------------------------
// triangular_matrix_unpack_addresses_core_test: top of the unpack testbench
// Drives packed weight requests under a sequence of layout and node count
// settings, with bursty requests and a stalling write sink, and reports the
// verdict from the write checker.
// ----------------------------------------------------------------------------
module triangular_matrix_unpack_addresses_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmu_pkg::*;

    localparam int MAX_N      = MAX_N_DEFAULT;
    localparam int IDX_W      = $clog2(MAX_N);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int CFG_DATA_W = ($clog2(MAX_N + 1) > 11) ? $clog2(MAX_N + 1) : 11;

    localparam int TOTAL_WEIGHTS  = 950;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_PHASE     = 11;
    localparam int WATCHDOG_LIMIT = 2000;

    // Indexes past the two defined registers.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Undefined layout codes, which must behave as the full layout.
    localparam logic [LAYOUT_W-1:0] LAY_UNDEF_FIRST = 4'd9;
    localparam logic [LAYOUT_W-1:0] LAY_UNDEF_LAST  = 4'd15;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_mode_e;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       out_valid;
    logic                       out_ready;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic [ADDR_W-1:0]          cell_address;
    logic signed [WEIGHT_W-1:0] cell_value;
    logic                       last_of_run;
    logic                       section_done;

    int mismatch_count;
    int pending_writes;
    int weights_sent = 0;
    int burst_left = 0;
    int stuck_cycles = 0;
    int node_setting = 2;
    bit hold_req = 1'b0;

    triangular_matrix_unpack_addresses_core #(.MAX_N(MAX_N)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row          (row),
        .col          (col),
        .cell_address (cell_address),
        .cell_value   (cell_value),
        .last_of_run  (last_of_run),
        .section_done (section_done)
    );

    tmu_cell_write_checker #(.MAX_N(MAX_N)) write_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .weight         (weight),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row            (row),
        .col            (col),
        .cell_address   (cell_address),
        .cell_value     (cell_value),
        .last_of_run    (last_of_run),
        .section_done   (section_done),
        .mismatch_count (mismatch_count),
        .pending_writes (pending_writes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Called just after a falling edge; returns at the falling edge after the
    // request was accepted, with valid still high.
    task automatic send_weight(input logic signed [WEIGHT_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        weight <= w;
        do
            @(posedge clk);
        while (!in_ready);
        weights_sent++;
        @(negedge clk);
    endtask

    // Drops the request line and waits until every predicted write is out.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_writes != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_NODE_COUNT)
            node_setting = int'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? WEIGHT_MAX : WEIGHT_MIN;
            1:       return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_node_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(MAX_N);
            3:       return {CFG_DATA_W{1'b1}};
            4:       return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
            5, 6:    return CFG_DATA_W'($urandom_range(7, 16));
            default: return CFG_DATA_W'($urandom_range(2, 6));
        endcase
    endfunction

    // Write sink: changing ready patterns, plus one long hold-off on request.
    initial
    begin
        ready_mode_e mode;
        int          mode_left;
        out_ready = 1'b0;
        mode = READY_ALWAYS;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = ready_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                    READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
            stuck_cycles++;
        else
            stuck_cycles = 0;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int                    phase;
        int                    count;
        int                    cfg_pick;
        logic [LAYOUT_W-1:0]   lay;
        logic [CFG_DATA_W-1:0] lay_word;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LAYOUT;
        cfg_data = '0;
        in_valid = 1'b0;
        weight = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration is a full 2x2 matrix: one whole section.
        send_weight(WEIGHT_MAX);
        send_weight(WEIGHT_MIN);
        send_weight('0);
        send_weight(-1);
        wait_until_idle();

        write_reg(REG_LAYOUT, CFG_DATA_W'(LAY_UPPER_ROW));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(3));
        send_weight(random_weight());
        wait_until_idle();
        // Writes to undefined indexes must not restart the section.
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        send_weight(random_weight());
        send_weight(random_weight());
        wait_until_idle();

        // Undefined layout and a node count below the minimum.
        write_reg(REG_LAYOUT, CFG_DATA_W'(LAY_UNDEF_LAST));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(1));
        repeat (4) send_weight(random_weight());
        wait_until_idle();

        // Node count above the maximum is clamped.
        write_reg(REG_NODE_COUNT, {CFG_DATA_W{1'b1}});
        write_reg(REG_LAYOUT, CFG_DATA_W'(LAY_LOWER_DIAG_COL));
        repeat (3) send_weight(random_weight());
        wait_until_idle();

        write_reg(REG_LAYOUT, CFG_DATA_W'(LAY_FULL));
        write_reg(REG_NODE_COUNT, CFG_DATA_W'(MAX_N));
        repeat (2) send_weight(random_weight());
        wait_until_idle();

        write_reg(REG_NODE_COUNT, '0);
        write_reg(REG_LAYOUT, CFG_DATA_W'(LAY_LOWER_COL));
        send_weight(random_weight());

        phase = 0;
        while (weights_sent < TOTAL_WEIGHTS)
        begin
            wait_until_idle();
            cfg_pick = $urandom_range(0, 9);
            if (phase <= int'(LAY_LOWER_DIAG_COL) || cfg_pick >= 3)
            begin
                if (phase <= int'(LAY_LOWER_DIAG_COL))
                    lay = LAYOUT_W'(phase);
                else if ($urandom_range(0, 3) == 0)
                    lay = LAYOUT_W'($urandom_range(LAY_UNDEF_FIRST, LAY_UNDEF_LAST));
                else
                    lay = LAYOUT_W'($urandom_range(LAY_FULL, LAY_LOWER_DIAG_COL));
                // Bits above the layout field are don't-care.
                lay_word = CFG_DATA_W'($urandom);
                lay_word[LAYOUT_W-1:0] = lay;
                write_reg(REG_LAYOUT, lay_word);
            end
            if (cfg_pick == 1 || cfg_pick >= 5)
                write_reg(REG_NODE_COUNT, pick_node_count());
            if (cfg_pick == 2)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));

            // Large matrices only get a short run of requests.
            count = (node_setting > 16) ? $urandom_range(4, 12) : $urandom_range(3, 45);
            if (phase == HOLD_PHASE)
            begin
                hold_req = 1'b1;
                count = 40;
            end
            repeat (count) send_weight(random_weight());
            phase++;
        end

        wait_until_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tmu_pkg.sv
sv/triangular_matrix_unpack_addresses_core.sv
tb/tmu_cell_write_checker.sv
tb/triangular_matrix_unpack_addresses_core_test.sv
